[src/memory_test_pattern_checker_core_defines.svh]
// Assertion macros used by the checker RTL.
`ifndef MEMORY_TEST_PATTERN_CHECKER_CORE_DEFINES_SVH
`define MEMORY_TEST_PATTERN_CHECKER_CORE_DEFINES_SVH

// Concurrent check sampled on the rising clock, disabled while reset is high.
`define MTPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check with reset ignored, for properties that also hold during reset.
`define MTPC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/mtpc_pkg.sv]
package mtpc_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned CNT_W  = 31;

   localparam logic [1:0] CMD_RESTART = 2'd0;
   localparam logic [1:0] CMD_WRITE   = 2'd1;
   localparam logic [1:0] CMD_CHECK   = 2'd2;
   localparam logic [1:0] CMD_NONE    = 2'd3;

   localparam logic [1:0] MODE_RANDOM  = 2'd0;
   localparam logic [1:0] MODE_ADDRESS = 2'd1;
   localparam logic [1:0] MODE_COUNTER = 2'd2;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_LONG = 2'd2;

   localparam logic [2:0] REG_PATTERN_MODE  = 3'd0;
   localparam logic [2:0] REG_WORD_SIZE     = 3'd1;
   localparam logic [2:0] REG_SEED_BASE     = 3'd2;
   localparam logic [2:0] REG_PASS_NUMBER   = 3'd3;
   localparam logic [2:0] REG_BYTE_SWAP     = 3'd4;
   localparam logic [2:0] REG_START_ADDRESS = 3'd5;
   localparam logic [2:0] REG_END_ADDRESS   = 3'd6;
   localparam logic [2:0] REG_ERR_LIMIT     = 3'd7;

   localparam logic [DATA_W-1:0] SEED_RESET = 32'habcdef02;
   localparam logic [DATA_W-1:0] LCG_ADD    = 32'd13849;
   localparam logic [DATA_W-1:0] ADDR_STEP  = 32'd4;
   localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

   typedef struct packed {
      logic [1:0]        pattern_mode;
      logic [1:0]        word_size;
      logic [DATA_W-1:0] seed_base;
      logic [15:0]       pass_number;
      logic              byte_swap;
      logic [DATA_W-1:0] start_address;
      logic [DATA_W-1:0] end_address;
      logic [CNT_W-1:0]  err_limit;
   } cfg_type;

   function automatic logic [DATA_W-1:0] bswap32(input logic [DATA_W-1:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   // p * 8197 + 13849, with 8197 = 8192 + 4 + 1
   function automatic logic [DATA_W-1:0] lcg(input logic [DATA_W-1:0] p);
      return (p << 13) + (p << 2) + p + LCG_ADD;
   endfunction

endpackage

[src/mtpc_csr.sv]
module mtpc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [2:0]                  wr_index,
   input  logic [mtpc_pkg::DATA_W-1:0] wr_data,
   output mtpc_pkg::cfg_type           cfg
);

   mtpc_pkg::cfg_type cfg_ff;
   mtpc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            mtpc_pkg::REG_PATTERN_MODE:  cfg_in.pattern_mode  = wr_data[1:0];
            mtpc_pkg::REG_WORD_SIZE:     cfg_in.word_size     = wr_data[1:0];
            mtpc_pkg::REG_SEED_BASE:     cfg_in.seed_base     = wr_data;
            mtpc_pkg::REG_PASS_NUMBER:   cfg_in.pass_number   = wr_data[15:0];
            mtpc_pkg::REG_BYTE_SWAP:     cfg_in.byte_swap     = wr_data[0];
            mtpc_pkg::REG_START_ADDRESS: cfg_in.start_address = wr_data;
            mtpc_pkg::REG_END_ADDRESS:   cfg_in.end_address   = wr_data;
            mtpc_pkg::REG_ERR_LIMIT:
               cfg_in.err_limit = wr_data[mtpc_pkg::CNT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_mode  <= mtpc_pkg::MODE_RANDOM;
         cfg_ff.word_size     <= mtpc_pkg::SIZE_LONG;
         cfg_ff.seed_base     <= mtpc_pkg::SEED_RESET;
         cfg_ff.pass_number   <= '0;
         cfg_ff.byte_swap     <= 1'b0;
         cfg_ff.start_address <= '0;
         cfg_ff.end_address   <= '0;
         cfg_ff.err_limit     <= mtpc_pkg::CNT_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/mtpc_pattern.sv]
module mtpc_pattern (
   input  mtpc_pkg::cfg_type           cfg,
   input  logic [1:0]                  command,
   input  logic [mtpc_pkg::DATA_W-1:0] pattern,
   input  logic [mtpc_pkg::DATA_W-1:0] address,
   output logic [mtpc_pkg::DATA_W-1:0] pattern_next,
   output logic [mtpc_pkg::DATA_W-1:0] expected
);

   logic [mtpc_pkg::DATA_W-1:0] random_next;
   logic [mtpc_pkg::DATA_W-1:0] seed_sum;

   always_comb begin
      case (cfg.word_size)
         mtpc_pkg::SIZE_BYTE:
            random_next = mtpc_pkg::lcg({pattern[23:0], pattern[31:24]});
         mtpc_pkg::SIZE_HALF:
            random_next = mtpc_pkg::lcg({pattern[15:0], pattern[31:16]});
         default: begin
            if (cfg.byte_swap) begin
               random_next = mtpc_pkg::bswap32(mtpc_pkg::lcg(mtpc_pkg::bswap32(pattern)));
            end else begin
               random_next = mtpc_pkg::lcg(pattern);
            end
         end
      endcase
   end

   assign seed_sum = cfg.seed_base + {16'd0, cfg.pass_number};

   always_comb begin
      pattern_next = pattern;
      expected     = '0;
      if (command == mtpc_pkg::CMD_RESTART) begin
         if (cfg.pattern_mode == mtpc_pkg::MODE_RANDOM) begin
            pattern_next = cfg.byte_swap ? mtpc_pkg::bswap32(seed_sum) : seed_sum;
         end else begin
            pattern_next = '0;
         end
      end else begin
         case (cfg.pattern_mode)
            mtpc_pkg::MODE_RANDOM: begin
               pattern_next = random_next;
               expected     = random_next;
            end
            mtpc_pkg::MODE_ADDRESS: begin
               expected = address;
            end
            default: begin
               pattern_next = pattern + 32'd1;
               expected     = pattern + 32'd1;
            end
         endcase
      end
   end

endmodule

[src/memory_test_pattern_checker_core.sv]
// Memory test pattern generator and checker.
// Input channel (req_): one command per transfer. Restart reloads the
// address and pattern (the seed in random mode, else 0); write and check
// step it; check compares req_read_data. Command 3 is dropped, no result.
// Result channel (rsp_): one transfer per restart, write or check, carrying
// expected word, byte address, mismatch flag, saturating error count, the
// error limit flag and a last-word flag for the end of the region.
// Configuration (csr_): eight registers by index, always ready; write them
// only while no command is in flight.
// The command transfer loads the input register, which then loads the
// result register unless that holds a stalled result. Throughput is one
// command per cycle while no result is held; the pattern step, compare
// and count all sit in the one stage between those two registers.
// Reset (synchronous, active high) loads register defaults, the seed
// 0xabcdef02, address 0 and error count 0, and empties both registers.
// When rsp_stall holds a result, the input register still takes one more
// command; beyond that req_stall rises until the result moves.
`include "memory_test_pattern_checker_core_defines.svh"

module memory_test_pattern_checker_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_command,
   input  logic [mtpc_pkg::DATA_W-1:0] req_read_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mtpc_pkg::DATA_W-1:0] rsp_expected_word,
   output logic [mtpc_pkg::DATA_W-1:0] rsp_word_address,
   output logic                        rsp_mismatch,
   output logic [mtpc_pkg::CNT_W-1:0]  rsp_error_count,
   output logic                        rsp_limit_reached,
   output logic                        rsp_last_word,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [mtpc_pkg::DATA_W-1:0] csr_wdata
);

   mtpc_pkg::cfg_type cfg;

   logic                        s1_valid_ff, s1_valid_in;
   logic [1:0]                  s1_command_ff;
   logic [mtpc_pkg::DATA_W-1:0] s1_read_data_ff;

   logic [mtpc_pkg::DATA_W-1:0] pattern_ff, pattern_in;
   logic [mtpc_pkg::DATA_W-1:0] address_ff, address_in;
   logic [mtpc_pkg::CNT_W-1:0]  total_ff, total_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mtpc_pkg::DATA_W-1:0] rsp_expected_ff, rsp_address_ff;
   logic                        rsp_mismatch_ff, rsp_limit_ff, rsp_last_ff;
   logic [mtpc_pkg::CNT_W-1:0]  rsp_count_ff;

   logic                        advance, fire, restart;
   logic [mtpc_pkg::DATA_W-1:0] pattern_next, expected;
   logic [mtpc_pkg::DATA_W-1:0] word_address;
   logic [mtpc_pkg::DATA_W:0]   end_diff;
   logic                        last_word, mismatch;

   assign csr_ready = 1'b1;

   mtpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   mtpc_pattern u_pattern (
      .cfg          (cfg),
      .command      (s1_command_ff),
      .pattern      (pattern_ff),
      .address      (address_ff),
      .pattern_next (pattern_next),
      .expected     (expected)
   );

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign fire      = s1_valid_ff && advance && (s1_command_ff != mtpc_pkg::CMD_NONE);
   assign restart   = s1_command_ff == mtpc_pkg::CMD_RESTART;

   assign word_address = restart ? cfg.start_address : address_ff;
   assign end_diff     = {1'b0, cfg.end_address} - {1'b0, address_ff};
   assign last_word    = !restart && !end_diff[mtpc_pkg::DATA_W] &&
                         (end_diff[mtpc_pkg::DATA_W-1:0] != '0) &&
                         (end_diff[mtpc_pkg::DATA_W-1:0] <= mtpc_pkg::ADDR_STEP);
   assign mismatch     = (s1_command_ff == mtpc_pkg::CMD_CHECK) &&
                         (s1_read_data_ff != expected);

   always_comb begin
      s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
      rsp_valid_in = advance ? fire : rsp_valid_ff;
      pattern_in   = pattern_ff;
      address_in   = address_ff;
      total_in     = total_ff;
      if (fire) begin
         pattern_in = pattern_next;
         address_in = restart ? cfg.start_address : address_ff + mtpc_pkg::ADDR_STEP;
         if (mismatch && (total_ff != mtpc_pkg::CNT_MAX)) begin
            total_in = total_ff + 31'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pattern_ff   <= mtpc_pkg::SEED_RESET;
         address_ff   <= '0;
         total_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pattern_ff   <= pattern_in;
         address_ff   <= address_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_command_ff   <= req_command;
         s1_read_data_ff <= req_read_data;
      end
      if (fire) begin
         rsp_expected_ff <= expected;
         rsp_address_ff  <= word_address;
         rsp_mismatch_ff <= mismatch;
         rsp_count_ff    <= total_in;
         rsp_limit_ff    <= total_in >= cfg.err_limit;
         rsp_last_ff     <= last_word;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_expected_word = rsp_expected_ff;
   assign rsp_word_address  = rsp_address_ff;
   assign rsp_mismatch      = rsp_mismatch_ff;
   assign rsp_error_count   = rsp_count_ff;
   assign rsp_limit_reached = rsp_limit_ff;
   assign rsp_last_word     = rsp_last_ff;

   `MTPC_ASSERT(a_stall_cause, clock, reset, req_stall |-> (rsp_valid_ff && rsp_stall), "stall")
   `MTPC_ASSERT(a_mis_count, clock, reset, (rsp_valid_ff && rsp_mismatch_ff) |-> (rsp_count_ff != '0), "count")
   `MTPC_ASSERT(a_addr_step, clock, reset, (fire && !restart) |=> (address_ff == $past(address_ff) + mtpc_pkg::ADDR_STEP), "addr")
   `MTPC_ASSERT(a_count_step, clock, reset, (!$past(reset) && (total_ff != $past(total_ff))) |-> (total_ff == $past(total_ff) + 31'd1), "step")

endmodule

[bench/memory_test_pattern_checker_core_tb.sv]
`timescale 1ns / 1ps

module memory_test_pattern_checker_core_tb;

   localparam logic [1:0]  MODE_SPARE   = 2'd3;
   localparam logic [1:0]  SIZE_SPARE   = 2'd3;
   localparam logic [31:0] LCG_MUL      = 32'd8197;
   localparam int unsigned RUN_LIMIT_NS = 3_000_000;
   localparam int unsigned RANDOM_ITEMS = 1500;
   localparam int unsigned LONG_HOLD    = 300;

   typedef struct packed {
      logic [31:0] word;
      logic [31:0] addr;
      logic        mis;
      logic [30:0] count;
      logic        limit;
      logic        last;
   } word_result_type;

   typedef struct packed {
      bit              is_reg;
      logic [2:0]      idx;
      logic [1:0]      cmd;
      logic [31:0]     data;
      bit              typed;
      word_result_type want;
   } step_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_command;
   logic [31:0] req_read_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_expected_word;
   logic [31:0] rsp_word_address;
   logic        rsp_mismatch;
   logic [30:0] rsp_error_count;
   logic        rsp_limit_reached;
   logic        rsp_last_word;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   mtpc_pkg::cfg_type cfg;
   logic [31:0]       pat_q;
   logic [31:0]       addr_q;
   logic [30:0]       err_q;
   word_result_type   pending_words [$];
   step_type          script [$];
   int                fault_total = 0;
   bit                feed_calm = 1'b0;
   bit                sink_calm = 1'b0;
   int                hold_off_cycles = 0;

   memory_test_pattern_checker_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_read_data     (req_read_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_expected_word (rsp_expected_word),
      .rsp_word_address  (rsp_word_address),
      .rsp_mismatch      (rsp_mismatch),
      .rsp_error_count   (rsp_error_count),
      .rsp_limit_reached (rsp_limit_reached),
      .rsp_last_word     (rsp_last_word),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] swap_bytes(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic [31:0] lcg_next(input logic [31:0] p);
      return p * LCG_MUL + mtpc_pkg::LCG_ADD;
   endfunction

   function automatic logic [31:0] stepped_pattern(input logic [31:0] p, input logic [31:0] a);
      logic [31:0] r;
      case (cfg.pattern_mode)
         mtpc_pkg::MODE_RANDOM: begin
            case (cfg.word_size)
               mtpc_pkg::SIZE_BYTE: r = lcg_next({p[23:0], p[31:24]});
               mtpc_pkg::SIZE_HALF: r = lcg_next({p[15:0], p[31:16]});
               default:
                  r = cfg.byte_swap ? swap_bytes(lcg_next(swap_bytes(p))) : lcg_next(p);
            endcase
         end
         mtpc_pkg::MODE_ADDRESS: r = a;
         default:                r = p + 32'd1;
      endcase
      return r;
   endfunction

   function automatic word_result_type advance_checker(input logic [1:0] cmd,
                                                       input logic [31:0] rd);
      word_result_type r;
      logic [31:0]     seed;
      r = '0;
      r.addr = (cmd == mtpc_pkg::CMD_RESTART) ? cfg.start_address : addr_q;
      if (cmd == mtpc_pkg::CMD_RESTART) begin
         seed = cfg.seed_base + {16'h0, cfg.pass_number};
         addr_q = cfg.start_address;
         if (cfg.pattern_mode == mtpc_pkg::MODE_RANDOM)
            pat_q = cfg.byte_swap ? swap_bytes(seed) : seed;
         else
            pat_q = 32'h0;
      end else begin
         r.word = stepped_pattern(pat_q, addr_q);
         if (cfg.pattern_mode != mtpc_pkg::MODE_ADDRESS)
            pat_q = r.word;
         r.last = (addr_q < cfg.end_address) &&
                  (cfg.end_address - addr_q <= mtpc_pkg::ADDR_STEP);
         if (cmd == mtpc_pkg::CMD_CHECK && rd != r.word) begin
            r.mis = 1'b1;
            if (err_q != mtpc_pkg::CNT_MAX)
               err_q = err_q + 31'd1;
         end
         addr_q = addr_q + mtpc_pkg::ADDR_STEP;
      end
      r.count = err_q;
      r.limit = (err_q >= cfg.err_limit);
      return r;
   endfunction

   function automatic step_type cmd_row(input logic [1:0] cmd, input logic [31:0] rd);
      step_type s;
      s = '0;
      s.cmd = cmd;
      s.data = rd;
      return s;
   endfunction

   function automatic step_type known_row(input logic [1:0] cmd, input logic [31:0] rd,
                                          input logic [31:0] word, input logic [31:0] addr,
                                          input logic mis, input logic [30:0] count,
                                          input logic limit, input logic last);
      step_type s;
      s = cmd_row(cmd, rd);
      s.typed = 1'b1;
      s.want = '{word: word, addr: addr, mis: mis, count: count, limit: limit, last: last};
      return s;
   endfunction

   function automatic step_type reg_row(input logic [2:0] idx, input logic [31:0] data);
      step_type s;
      s = '0;
      s.is_reg = 1'b1;
      s.idx = idx;
      s.data = data;
      return s;
   endfunction

   task automatic note_fault(input string what, input logic [31:0] got, input logic [31:0] want);
      fault_total++;
      $display("%0t: %s got %h want %h", $time, what, got, want);
   endtask

   task automatic send_item(input logic [1:0] cmd, input logic [31:0] rd, input bit typed,
                            input word_result_type want);
      int              gap;
      word_result_type predicted;
      gap = feed_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_read_data <= rd;
      do @(posedge clock); while (req_stall);
      if (cmd != mtpc_pkg::CMD_NONE) begin
         predicted = advance_checker(cmd, rd);
         pending_words.push_back(typed ? want : predicted);
      end
      @(negedge clock);
   endtask

   task automatic idle_wait();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         mtpc_pkg::REG_PATTERN_MODE:  cfg.pattern_mode  = data[1:0];
         mtpc_pkg::REG_WORD_SIZE:     cfg.word_size     = data[1:0];
         mtpc_pkg::REG_SEED_BASE:     cfg.seed_base     = data;
         mtpc_pkg::REG_PASS_NUMBER:   cfg.pass_number   = data[15:0];
         mtpc_pkg::REG_BYTE_SWAP:     cfg.byte_swap     = data[0];
         mtpc_pkg::REG_START_ADDRESS: cfg.start_address = data;
         mtpc_pkg::REG_END_ADDRESS:   cfg.end_address   = data;
         mtpc_pkg::REG_ERR_LIMIT:     cfg.err_limit     = data[30:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic program_regs(input int phase);
      logic [31:0] v_mode, v_size, v_seed, v_pass, v_swap, region_lo, region_hi, err_cap;
      idle_wait();
      if (phase < 2) begin
         v_mode = (phase == 0) ? 32'h0 : 32'hffff_ffff;
         v_size = v_mode;
         v_seed = v_mode;
         v_pass = v_mode;
         v_swap = v_mode;
         region_lo = v_mode;
         region_hi = v_mode;
         err_cap = v_mode;
      end else begin
         v_mode = $urandom();
         v_size = $urandom();
         v_pass = $urandom();
         v_swap = $urandom();
         case ($urandom_range(0, 3))
            0:       v_seed = 32'h0;
            1:       v_seed = 32'hffff_ffff;
            default: v_seed = $urandom();
         endcase
         case ($urandom_range(0, 3))
            0:       region_lo = 32'h0;
            1:       region_lo = 32'hffff_ff00 | ($urandom() & 32'h0000_00fc);
            2:       region_lo = $urandom();
            default: region_lo = $urandom() & ~32'h3;
         endcase
         region_hi = ($urandom_range(0, 4) == 0) ? $urandom()
                                                 : region_lo + $urandom_range(1, 160);
         case ($urandom_range(0, 3))
            0:       err_cap = 32'h0;
            1:       err_cap = 32'hffff_ffff;
            2:       err_cap = {1'b0, err_q} + $urandom_range(0, 25);
            default: err_cap = $urandom();
         endcase
      end
      write_reg(mtpc_pkg::REG_PATTERN_MODE, v_mode);
      write_reg(mtpc_pkg::REG_WORD_SIZE, v_size);
      write_reg(mtpc_pkg::REG_SEED_BASE, v_seed);
      write_reg(mtpc_pkg::REG_PASS_NUMBER, v_pass);
      write_reg(mtpc_pkg::REG_BYTE_SWAP, v_swap);
      write_reg(mtpc_pkg::REG_START_ADDRESS, region_lo);
      write_reg(mtpc_pkg::REG_END_ADDRESS, region_hi);
      write_reg(mtpc_pkg::REG_ERR_LIMIT, err_cap);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : watch_results
      word_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            note_fault("result with nothing pending, word", rsp_expected_word, 32'h0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_expected_word !== want.word)
               note_fault("expected_word", rsp_expected_word, want.word);
            if (rsp_word_address !== want.addr)
               note_fault("word_address", rsp_word_address, want.addr);
            if (rsp_mismatch !== want.mis)
               note_fault("mismatch", {31'h0, rsp_mismatch}, {31'h0, want.mis});
            if (rsp_error_count !== want.count)
               note_fault("error_count", {1'b0, rsp_error_count}, {1'b0, want.count});
            if (rsp_limit_reached !== want.limit)
               note_fault("limit_reached", {31'h0, rsp_limit_reached}, {31'h0, want.limit});
            if (rsp_last_word !== want.last)
               note_fault("last_word", {31'h0, rsp_last_word}, {31'h0, want.last});
         end
      end
   end

   initial begin : result_sink
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            hold = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            hold = sink_calm ? 0 : $urandom_range(0, 9);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int          phase, span, k, pick, items_sent;
      bit          regs_open;
      logic [1:0]  cmd;
      logic [31:0] rd, word;

      reset = 1'b1;
      req_valid = 1'b0;
      req_command = mtpc_pkg::CMD_NONE;
      req_read_data = 32'h0;
      csr_valid = 1'b0;
      csr_index = mtpc_pkg::REG_PATTERN_MODE;
      csr_wdata = 32'h0;
      cfg = '{pattern_mode: mtpc_pkg::MODE_RANDOM, word_size: mtpc_pkg::SIZE_LONG,
              seed_base: mtpc_pkg::SEED_RESET, pass_number: 16'h0, byte_swap: 1'b0,
              start_address: 32'h0, end_address: 32'h0, err_limit: mtpc_pkg::CNT_MAX};
      pat_q = mtpc_pkg::SEED_RESET;
      addr_q = 32'h0;
      err_q = 31'h0;

      script = '{
         known_row(mtpc_pkg::CMD_RESTART, 32'h0, 32'h0, 32'h0, 1'b0, 31'd0, 1'b0, 1'b0),
         cmd_row(mtpc_pkg::CMD_NONE, 32'hffff_ffff),
         cmd_row(mtpc_pkg::CMD_WRITE, 32'hffff_ffff),
         reg_row(mtpc_pkg::REG_PATTERN_MODE, {30'h0, mtpc_pkg::MODE_COUNTER}),
         reg_row(mtpc_pkg::REG_START_ADDRESS, 32'hffff_fff8),
         reg_row(mtpc_pkg::REG_END_ADDRESS, 32'hffff_fffc),
         reg_row(mtpc_pkg::REG_ERR_LIMIT, 32'h0),
         known_row(mtpc_pkg::CMD_RESTART, 32'h0, 32'h0, 32'hffff_fff8,
                   1'b0, 31'd0, 1'b1, 1'b0),
         known_row(mtpc_pkg::CMD_WRITE, 32'h0, 32'h1, 32'hffff_fff8,
                   1'b0, 31'd0, 1'b1, 1'b1),
         known_row(mtpc_pkg::CMD_CHECK, 32'h2, 32'h2, 32'hffff_fffc,
                   1'b0, 31'd0, 1'b1, 1'b0),
         known_row(mtpc_pkg::CMD_CHECK, 32'h0, 32'h3, 32'h0, 1'b1, 31'd1, 1'b1, 1'b0),
         known_row(mtpc_pkg::CMD_CHECK, 32'hffff_ffff, 32'h4, 32'h4,
                   1'b1, 31'd2, 1'b1, 1'b0),
         reg_row(mtpc_pkg::REG_PATTERN_MODE, {30'h0, mtpc_pkg::MODE_ADDRESS}),
         reg_row(mtpc_pkg::REG_ERR_LIMIT, 32'h3),
         known_row(mtpc_pkg::CMD_RESTART, 32'h0, 32'h0, 32'hffff_fff8,
                   1'b0, 31'd2, 1'b0, 1'b0),
         known_row(mtpc_pkg::CMD_CHECK, 32'hffff_fff8, 32'hffff_fff8, 32'hffff_fff8,
                   1'b0, 31'd2, 1'b0, 1'b1),
         known_row(mtpc_pkg::CMD_CHECK, 32'h0, 32'hffff_fffc, 32'hffff_fffc,
                   1'b1, 31'd3, 1'b1, 1'b0),
         reg_row(mtpc_pkg::REG_PATTERN_MODE, {30'h0, MODE_SPARE}),
         reg_row(mtpc_pkg::REG_WORD_SIZE, {30'h0, mtpc_pkg::SIZE_BYTE}),
         known_row(mtpc_pkg::CMD_RESTART, 32'h0, 32'h0, 32'hffff_fff8,
                   1'b0, 31'd3, 1'b1, 1'b0),
         known_row(mtpc_pkg::CMD_WRITE, 32'h0, 32'h1, 32'hffff_fff8,
                   1'b0, 31'd3, 1'b1, 1'b1),
         cmd_row(mtpc_pkg::CMD_CHECK, 32'h0),
         reg_row(mtpc_pkg::REG_PATTERN_MODE, {30'h0, mtpc_pkg::MODE_RANDOM}),
         reg_row(mtpc_pkg::REG_SEED_BASE, 32'hffff_ffff),
         reg_row(mtpc_pkg::REG_PASS_NUMBER, 32'hffff_ffff),
         reg_row(mtpc_pkg::REG_BYTE_SWAP, 32'hffff_ffff),
         reg_row(mtpc_pkg::REG_START_ADDRESS, 32'h0),
         reg_row(mtpc_pkg::REG_END_ADDRESS, 32'h8),
         reg_row(mtpc_pkg::REG_ERR_LIMIT, 32'hffff_ffff),
         cmd_row(mtpc_pkg::CMD_RESTART, 32'h0),
         cmd_row(mtpc_pkg::CMD_WRITE, 32'h0),
         cmd_row(mtpc_pkg::CMD_CHECK, 32'h0),
         cmd_row(mtpc_pkg::CMD_CHECK, 32'hffff_ffff),
         reg_row(mtpc_pkg::REG_WORD_SIZE, {30'h0, mtpc_pkg::SIZE_HALF}),
         cmd_row(mtpc_pkg::CMD_WRITE, 32'h1234_5678),
         cmd_row(mtpc_pkg::CMD_CHECK, 32'h8765_4321),
         reg_row(mtpc_pkg::REG_WORD_SIZE, {30'h0, SIZE_SPARE}),
         cmd_row(mtpc_pkg::CMD_WRITE, 32'h0),
         cmd_row(mtpc_pkg::CMD_CHECK, 32'hffff_ffff),
         reg_row(mtpc_pkg::REG_WORD_SIZE, {30'h0, mtpc_pkg::SIZE_LONG}),
         reg_row(mtpc_pkg::REG_BYTE_SWAP, 32'h0),
         cmd_row(mtpc_pkg::CMD_RESTART, 32'hffff_ffff),
         cmd_row(mtpc_pkg::CMD_WRITE, 32'h0)
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      regs_open = 1'b0;
      foreach (script[i]) begin
         if (script[i].is_reg) begin
            if (!regs_open) begin
               idle_wait();
               regs_open = 1'b1;
            end
            write_reg(script[i].idx, script[i].data);
         end else begin
            if (regs_open) begin
               csr_valid <= 1'b0;
               regs_open = 1'b0;
            end
            send_item(script[i].cmd, script[i].data, script[i].typed, script[i].want);
         end
      end

      items_sent = 0;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         program_regs(phase);
         feed_calm = ($urandom_range(0, 3) == 0);
         sink_calm = ($urandom_range(0, 3) == 0);
         if (phase == 3 || phase == 9) begin
            feed_calm = 1'b1;
            hold_off_cycles = LONG_HOLD;
         end
         span = $urandom_range(40, 120);
         for (k = 0; k < span; k++) begin
            pick = $urandom_range(0, 99);
            if (k == 0 || pick < 4)
               cmd = mtpc_pkg::CMD_RESTART;
            else if (pick < 9)
               cmd = mtpc_pkg::CMD_NONE;
            else if (pick < 50)
               cmd = mtpc_pkg::CMD_WRITE;
            else
               cmd = mtpc_pkg::CMD_CHECK;
            rd = $urandom();
            if (cmd == mtpc_pkg::CMD_CHECK) begin
               word = stepped_pattern(pat_q, addr_q);
               pick = $urandom_range(0, 99);
               if (pick < 70)
                  rd = word;
               else if (pick < 85)
                  rd = word ^ (32'h1 << $urandom_range(0, 31));
            end
            send_item(cmd, rd, 1'b0, '0);
            items_sent++;
         end
         phase++;
      end

      idle_wait();
      repeat (10) @(posedge clock);
      if (fault_total == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/mtpc_pkg.sv
src/mtpc_csr.sv
src/mtpc_pattern.sv
src/memory_test_pattern_checker_core.sv
bench/memory_test_pattern_checker_core_tb.sv
